// ===== rtl/core/escape_decode_utf8_emit_defines.svh =====
// Assertion macros shared by the escape decoder checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ESCAPE_DECODE_UTF8_EMIT_DEFINES_SVH
`define ESCAPE_DECODE_UTF8_EMIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EDU8_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape decoder assertion failed");

// Next-cycle implication, disabled while in reset.
`define EDU8_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape decoder assertion failed");

`endif

// ===== rtl/core/edu8_pkg.sv =====
// Shared types and constants for the escape decoder with UTF-8 output.
// No dependencies; used by the front, queue, back and top level.
`timescale 1ns / 1ps

package edu8_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int CP_W   = 21;

    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_BSL   = 8'h5C;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_LC_X  = 8'h78;
    localparam logic [7:0] BYTE_LC_R  = 8'h72;
    localparam logic [7:0] BYTE_LC_N  = 8'h6E;
    localparam logic [7:0] BYTE_LC_T  = 8'h74;

    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    localparam logic [7:0] LEAD_2     = 8'hC0;
    localparam logic [7:0] LEAD_3     = 8'hE0;
    localparam logic [7:0] LEAD_4     = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    // One decoded unit of work: a single byte, or a code point to be
    // written as cont + 1 UTF-8 bytes.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [1:0]      cont;
        logic            esc;
        logic            hx;
        logic            bad;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

endpackage

// ===== rtl/core/edu8_queue.sv =====
// Short command queue between the classifying front and the byte writer.
// Depends on edu8_pkg for the command type and depth.
`timescale 1ns / 1ps

module edu8_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  edu8_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output edu8_pkg::q_stat_t stat,
    output edu8_pkg::cmd_t  head
);
    import edu8_pkg::*;

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.avail = (count_reg != '0);

endmodule

// ===== rtl/core/edu8_front.sv =====
// Front end: accepts text bytes, tracks escape and hex state, and turns
// each byte that produces output into one queue command. Uses edu8_pkg.
`timescale 1ns / 1ps

module edu8_front #(
    parameter int HEX_ACC_BITS = 28
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  logic [7:0]        in_byte,
    input  logic              text_end,
    input  edu8_pkg::q_stat_t qstat,
    output logic              push,
    output edu8_pkg::cmd_t    push_cmd
);
    import edu8_pkg::*;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    mode_t                   mode_reg, mode_next;
    logic [HEX_ACC_BITS-1:0] hex_reg, hex_next;
    logic                    accept;
    logic                    digit_ok;
    logic [3:0]              digit;
    logic [CP_W-1:0]         cp;
    logic                    over_range;
    logic [1:0]              cont;
    logic [7:0]              esc_byte;

    assign src_stall  = qstat.full;
    assign accept     = src_valid & ~qstat.full;
    assign cp         = hex_reg[CP_W-1:0];
    assign over_range = (hex_reg > HEX_ACC_BITS'(CP_MAX));

    always_comb
    begin
        digit_ok = 1'b1;
        digit    = '0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            digit = in_byte[3:0];
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
        begin
            digit = 4'(in_byte - 8'h57);
        end
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
        begin
            digit = 4'(in_byte - 8'h37);
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    // Number of continuation bytes the code point will need.
    always_comb
    begin
        if (cp[CP_W-1:7] == '0)
        begin
            cont = 2'd0;
        end
        else if (cp[CP_W-1:11] == '0)
        begin
            cont = 2'd1;
        end
        else if (cp[CP_W-1:16] == '0)
        begin
            cont = 2'd2;
        end
        else
        begin
            cont = 2'd3;
        end
    end

    always_comb
    begin
        if (in_byte == BYTE_LC_R)
        begin
            esc_byte = BYTE_CR;
        end
        else if (in_byte == BYTE_LC_N)
        begin
            esc_byte = BYTE_LF;
        end
        else if (in_byte == BYTE_LC_T)
        begin
            esc_byte = BYTE_TAB;
        end
        else
        begin
            esc_byte = in_byte;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        push      = 1'b0;
        push_cmd  = '0;
        if (accept)
        begin
            // Carriage return is dropped in every mode, even inside a hex escape.
            if (in_byte != BYTE_CR)
            begin
                unique case (mode_reg)
                    MODE_ESC:
                    begin
                        if (in_byte == BYTE_LC_X)
                        begin
                            mode_next = MODE_HEX;
                            hex_next  = '0;
                        end
                        else
                        begin
                            mode_next    = MODE_PLAIN;
                            push         = 1'b1;
                            push_cmd.cp  = CP_W'(esc_byte);
                            push_cmd.esc = 1'b1;
                        end
                    end
                    MODE_HEX:
                    begin
                        if (digit_ok)
                        begin
                            hex_next = {hex_reg[HEX_ACC_BITS-5:0], digit};
                        end
                        else
                        begin
                            mode_next     = MODE_PLAIN;
                            hex_next      = '0;
                            push          = 1'b1;
                            push_cmd.cp   = cp;
                            push_cmd.cont = cont;
                            push_cmd.esc  = 1'b1;
                            push_cmd.hx   = 1'b1;
                            push_cmd.bad  = over_range | (in_byte != BYTE_SEMI);
                        end
                    end
                    default:
                    begin
                        if (in_byte == BYTE_BSL)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else
                        begin
                            mode_next    = MODE_PLAIN;
                            push         = 1'b1;
                            push_cmd.cp  = CP_W'(in_byte);
                            push_cmd.bad = (in_byte != BYTE_LF) && (in_byte != BYTE_TAB)
                                && ((in_byte < BYTE_SPACE) || (in_byte == BYTE_DEL));
                        end
                    end
                endcase
            end
            // An escape still open at the end of a text is discarded.
            if (text_end)
            begin
                mode_next = MODE_PLAIN;
                hex_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            hex_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
        end
    end

endmodule

// ===== rtl/core/edu8_back.sv =====
// Back end: takes commands from the queue and writes them out one byte a
// cycle while not stalled, splitting code points into UTF-8 sequences. Uses edu8_pkg.
`timescale 1ns / 1ps

module edu8_back (
    input  logic              clk,
    input  logic              rst_n,
    input  edu8_pkg::q_stat_t qstat,
    input  edu8_pkg::cmd_t    head,
    output logic              pop,
    output logic              dst_valid,
    input  logic              dst_stall,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic              was_escaped,
    output logic              from_hex,
    output logic              bad_input
);
    import edu8_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg, esc_reg, hx_reg, bad_reg;
    logic       slot_free;
    logic       fire;
    logic       last;
    logic [1:0] rem;
    logic [5:0] grp;
    logic [7:0] byte_val;

    assign slot_free = ~valid_reg | ~dst_stall;
    assign fire      = qstat.avail & slot_free;
    assign last      = (idx_reg == head.cont);
    assign pop       = fire & last;
    assign rem       = head.cont - idx_reg;

    always_comb
    begin
        unique case (rem)
            2'd0:    grp = head.cp[5:0];
            2'd1:    grp = head.cp[11:6];
            2'd2:    grp = head.cp[17:12];
            default: grp = {3'b000, head.cp[20:18]};
        endcase
    end

    // The first byte carries the length prefix; a single byte is sent as is.
    always_comb
    begin
        if (idx_reg == 2'd0)
        begin
            unique case (head.cont)
                2'd0:    byte_val = head.cp[7:0];
                2'd1:    byte_val = LEAD_2 | {3'b000, grp[4:0]};
                2'd2:    byte_val = LEAD_3 | {4'b0000, grp[3:0]};
                default: byte_val = LEAD_4 | {5'b00000, grp[2:0]};
            endcase
        end
        else
        begin
            byte_val = CONT_MARK | {2'b00, grp};
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg & dst_stall;
        if (fire)
        begin
            idx_next   = last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= byte_val;
            last_reg <= last;
            esc_reg  <= head.esc;
            hx_reg   <= head.hx;
            bad_reg  <= head.bad;
        end
    end

    assign dst_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign was_escaped = esc_reg;
    assign from_hex    = hx_reg;
    assign bad_input   = bad_reg;

endmodule

// ===== rtl/core/escape_decode_utf8_emit.sv =====
// Backslash escape decoder with UTF-8 output. One text byte is taken per cycle
// while the four-entry command queue has room; a result passes through the queue and then
// the output register, and bytes leave at one per cycle while dst_stall is low, a hex
// escape giving one to four UTF-8 bytes. Reset (rst_n, asynchronous) returns
// to plain mode, clears the hex accumulator, empties the queue and drops valid.
`timescale 1ns / 1ps

module escape_decode_utf8_emit #(
    parameter int HEX_ACC_BITS = 28
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] in_byte,
    input  logic       text_end,
    output logic       dst_valid,
    input  logic       dst_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       was_escaped,
    output logic       from_hex,
    output logic       bad_input
);
    import edu8_pkg::*;

    q_stat_t qstat;
    cmd_t    push_cmd;
    cmd_t    head;
    logic    push;
    logic    pop;

    edu8_front #(
        .HEX_ACC_BITS (HEX_ACC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .in_byte   (in_byte),
        .text_end  (text_end),
        .qstat     (qstat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    edu8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .stat     (qstat),
        .head     (head)
    );

    edu8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .head        (head),
        .pop         (pop),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .was_escaped (was_escaped),
        .from_hex    (from_hex),
        .bad_input   (bad_input)
    );

endmodule

// ===== rtl/core/edu8_checker.sv =====
// Port-level checks for escape_decode_utf8_emit, attached by a bind below.
// Depends on the assertion macros in escape_decode_utf8_emit_defines.svh.
`timescale 1ns / 1ps
`include "escape_decode_utf8_emit_defines.svh"

module edu8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       dst_valid,
    input logic       dst_stall,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       was_escaped,
    input logic       from_hex,
    input logic       bad_input
);

    // A held result keeps its byte.
    `EDU8_ASSERT_NEXT(a_hold, dst_valid && dst_stall, dst_valid && $stable(out_byte))

    // Hex output always counts as escaped.
    `EDU8_ASSERT_IMPL(a_hex_esc, dst_valid && from_hex, was_escaped)

    // A simple escape never raises an error.
    `EDU8_ASSERT_IMPL(a_esc_ok, dst_valid && was_escaped && !from_hex, !bad_input)

    // Within a UTF-8 sequence the next byte follows at once and is a continuation.
    `EDU8_ASSERT_NEXT(a_utf8_cont, dst_valid && !dst_stall && from_hex && !last_of_run, dst_valid && from_hex && out_byte[7:6] == 2'b10)

endmodule

bind escape_decode_utf8_emit edu8_checker u_edu8_checker (.*);
